@@ src/pkrc_pkg.sv @@
// ----------------------------------------------------------------------------
// pkrc_pkg - prompt keyword rule classifier package
// Sizes, keyword and rule tables, and the byte fold shared by the block.
// ----------------------------------------------------------------------------
package pkrc_pkg;

  // Longest keyword the window can hold
  localparam int MAX_KEYWORD_LEN = 12;
  localparam int HIST_DEPTH      = MAX_KEYWORD_LEN - 1;
  localparam int NUM_KEYWORDS    = 23;
  localparam int NUM_RULES       = 13;

  localparam int FILL_W = $clog2(HIST_DEPTH + 1);
  localparam int LEN_W  = $clog2(MAX_KEYWORD_LEN + 1);

  typedef logic [7:0]                        byte_t;
  typedef logic [3:0]                        reply_t;
  typedef logic [FILL_W-1:0]                 fill_t;
  typedef logic [LEN_W-1:0]                  len_t;
  typedef logic [NUM_KEYWORDS-1:0]           hits_t;
  typedef logic [MAX_KEYWORD_LEN-1:0][7:0]   window_t;

  localparam reply_t DEFAULT_REPLY = 4'd13;

  // Keyword text, right-justified: byte 0 is the final character, which
  // lines up with the newest byte of the window.
  localparam window_t KW_TEXT [NUM_KEYWORDS] = '{
    "gravity", "spanish", "translate", "summar", "reply", "helpfully",
    "intent", "classify", "json", "extract", "weather", "one sentence",
    "explain", "test failure", "fix this", "endpoint", "/health",
    "rename", "refactor", "unit test", "write a test", "debug", "error"
  };

  localparam len_t KW_LEN [NUM_KEYWORDS] = '{
    LEN_W'(7), LEN_W'(7), LEN_W'(9), LEN_W'(6), LEN_W'(5), LEN_W'(9),
    LEN_W'(6), LEN_W'(8), LEN_W'(4), LEN_W'(7), LEN_W'(7), LEN_W'(12),
    LEN_W'(7), LEN_W'(12), LEN_W'(8), LEN_W'(8), LEN_W'(7),
    LEN_W'(6), LEN_W'(8), LEN_W'(9), LEN_W'(12), LEN_W'(5), LEN_W'(5)
  };

  // Keyword set for each rule, in priority order
  localparam hits_t RULE_MASK [NUM_RULES] = '{
    hits_t'(23'h000001), hits_t'(23'h000006), hits_t'(23'h000008),
    hits_t'(23'h000030), hits_t'(23'h0000C0), hits_t'(23'h000300),
    hits_t'(23'h000400), hits_t'(23'h001800), hits_t'(23'h006000),
    hits_t'(23'h018000), hits_t'(23'h060000), hits_t'(23'h180000),
    hits_t'(23'h600000)
  };

  // Set where every keyword of the rule must be seen, not just one
  localparam logic [NUM_RULES-1:0] RULE_ALL = 13'b1_0000_0000_0000;

  // ASCII upper to lower case; everything else passes as is
  function automatic byte_t fold_byte(input byte_t c);
    byte_t r;
    r = c;
    if (c >= 8'h41 && c <= 8'h5A) begin
      r = c + 8'h20;
    end
    return r;
  endfunction

endpackage

@@ src/pkrc_if.sv @@
// ----------------------------------------------------------------------------
// pkrc_if - prompt and reply channels
// Valid/ready channels carrying prompt words in and reply words out.
// ----------------------------------------------------------------------------
interface pkrc_in_if;
  import pkrc_pkg::*;

  logic  valid;
  logic  ready;
  byte_t prompt_byte;
  logic  has_byte;
  logic  last_byte;

  modport source (output valid, prompt_byte, has_byte, last_byte, input ready);
  modport sink   (input valid, prompt_byte, has_byte, last_byte, output ready);
endinterface

interface pkrc_out_if;
  import pkrc_pkg::*;

  logic   valid;
  logic   ready;
  reply_t reply_index;

  modport source (output valid, reply_index, input ready);
  modport sink   (input valid, reply_index, output ready);
endinterface

@@ src/prompt_keyword_rule_classifier.sv @@
// ----------------------------------------------------------------------------
// prompt_keyword_rule_classifier - keyword rule classifier, top level
// Scans a prompt byte stream for fixed keywords and picks a reply rule.
// ----------------------------------------------------------------------------
// One prompt word is taken every cycle unless the input side is held. A
// word is captured in an input register, matched in the next cycle against
// all 23 keywords at once over the history shift register, and a word
// marked last loads its reply index into the output register. Only a last
// word waiting on a full, stalled output register holds the input side;
// other words always flow.
module prompt_keyword_rule_classifier (
  input  logic              clk,
  input  logic              rst,
  pkrc_in_if.sink           prompt_in,
  pkrc_out_if.source        reply_out
);
  import pkrc_pkg::*;

  // Input register
  logic  s1_valid;
  byte_t s1_byte;
  logic  s1_has;
  logic  s1_last;
  logic  s1_fire;

  // Prompt state
  byte_t recent [HIST_DEPTH];
  fill_t fill;
  hits_t hits;

  // Output register
  logic   out_valid;
  reply_t out_index;

  window_t win;
  len_t    avail;
  hits_t   match;
  hits_t   hits_next;
  reply_t  pick;

  // Stage advance: a last word needs room in the output register
  assign s1_fire         = s1_valid && (!s1_last || !out_valid || reply_out.ready);
  assign prompt_in.ready = !s1_valid || s1_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (prompt_in.ready) begin
      s1_valid <= prompt_in.valid;
    end
    if (prompt_in.valid && prompt_in.ready) begin
      s1_byte <= prompt_in.prompt_byte;
      s1_has  <= prompt_in.has_byte;
      s1_last <= prompt_in.last_byte;
    end
  end

  // Window: folded new byte, then history newest first
  always_comb begin
    win[0] = fold_byte(s1_byte);
    for (int j = 1; j < MAX_KEYWORD_LEN; j++) begin
      win[j] = recent[j-1];
    end
  end

  assign avail = LEN_W'(fill) + LEN_W'(1);

  pkrc_match u_match (
    .window (win),
    .avail  (avail),
    .hit    (match)
  );

  assign hits_next = hits | (s1_has ? match : '0);

  pkrc_select u_select (
    .hits        (hits_next),
    .reply_index (pick)
  );

  // History shift; entries past the fill count are never compared
  always_ff @(posedge clk) begin
    if (s1_fire && s1_has) begin
      recent[0] <= win[0];
      for (int j = 1; j < HIST_DEPTH; j++) begin
        recent[j] <= recent[j-1];
      end
    end
  end

  // Fill count and sticky hits, cleared at the end of each prompt
  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
      hits <= '0;
    end else if (s1_fire) begin
      if (s1_last) begin
        fill <= '0;
        hits <= '0;
      end else begin
        hits <= hits_next;
        if (s1_has && (fill != FILL_W'(HIST_DEPTH))) begin
          fill <= fill + FILL_W'(1);
        end
      end
    end
  end

  // Reply register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire && s1_last) begin
      out_valid <= 1'b1;
    end else if (reply_out.ready) begin
      out_valid <= 1'b0;
    end
    if (s1_fire && s1_last) begin
      out_index <= pick;
    end
  end

  assign reply_out.valid       = out_valid;
  assign reply_out.reply_index = out_index;

  // Checks
  a_reply_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_index <= DEFAULT_REPLY))
    else $error("reply index out of range");

  a_fill_range: assert property (@(posedge clk) disable iff (rst)
    fill <= FILL_W'(HIST_DEPTH))
    else $error("history fill past depth");

  a_prompt_clear: assert property (@(posedge clk) disable iff (rst)
    (s1_fire && s1_last) |=> (hits == '0 && fill == '0))
    else $error("prompt state not cleared after last word");

  a_hits_sticky: assert property (@(posedge clk) disable iff (rst)
    (s1_fire && !s1_last) |=> ((hits & $past(hits)) == $past(hits)))
    else $error("keyword hit lost within a prompt");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !reply_out.ready) |=> (out_valid && $stable(out_index)))
    else $error("pending reply dropped or changed");

endmodule

@@ src/pkrc_match.sv @@
// ----------------------------------------------------------------------------
// pkrc_match - keyword comparators
// Compares the byte window against every keyword in parallel.
// ----------------------------------------------------------------------------
module pkrc_match (
  input  pkrc_pkg::window_t window,
  input  pkrc_pkg::len_t    avail,
  output pkrc_pkg::hits_t   hit
);
  import pkrc_pkg::*;

  // A keyword hits when it fits in the valid bytes and every char agrees
  always_comb begin
    for (int k = 0; k < NUM_KEYWORDS; k++) begin
      hit[k] = (KW_LEN[k] != '0) && (KW_LEN[k] <= avail);
      for (int j = 0; j < MAX_KEYWORD_LEN; j++) begin
        if ((LEN_W'(j) < KW_LEN[k]) && (window[j] != KW_TEXT[k][j])) begin
          hit[k] = 1'b0;
        end
      end
    end
  end

endmodule

@@ src/pkrc_select.sv @@
// ----------------------------------------------------------------------------
// pkrc_select - rule priority pick
// Returns the first rule whose keyword condition holds, or the default.
// ----------------------------------------------------------------------------
module pkrc_select (
  input  pkrc_pkg::hits_t  hits,
  output pkrc_pkg::reply_t reply_index
);
  import pkrc_pkg::*;

  // Scan from lowest priority up so the highest priority wins
  always_comb begin
    hits_t got;
    reply_index = DEFAULT_REPLY;
    for (int r = NUM_RULES - 1; r >= 0; r--) begin
      got = hits & RULE_MASK[r];
      if (RULE_ALL[r] ? (got == RULE_MASK[r]) : (got != '0)) begin
        reply_index = reply_t'(r);
      end
    end
  end

endmodule

@@ sim/prompt_keyword_rule_classifier_test.sv @@
// ----------------------------------------------------------------------------
// prompt_keyword_rule_classifier_test - classifier regression bench
// Drives prompts word by word with random gaps and reply stalls. A
// scoreboard scans each byte against the keyword list, picks the expected
// reply rule at the end of each prompt, and checks every reply word.
// ----------------------------------------------------------------------------
module prompt_keyword_rule_classifier_test;
  import pkrc_pkg::*;

  localparam int KEYWORD_COUNT  = 23;
  localparam int RULE_COUNT     = 13;
  localparam int BOTH_KEYS_RULE = 12;   // debug AND error
  localparam int WINDOW_LEN     = 12;
  localparam int HISTORY_LEN    = WINDOW_LEN - 1;
  localparam int PHASE_WORDS    = 360;
  localparam int SETTLE_CYCLES  = 10;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int REPORT_LIMIT   = 10;

  // Keyword groups per reply rule, highest priority first
  localparam hits_t RULE_KEYS [RULE_COUNT] = '{
    hits_t'(23'h000001), hits_t'(23'h000006), hits_t'(23'h000008),
    hits_t'(23'h000030), hits_t'(23'h0000C0), hits_t'(23'h000300),
    hits_t'(23'h000400), hits_t'(23'h001800), hits_t'(23'h006000),
    hits_t'(23'h018000), hits_t'(23'h060000), hits_t'(23'h180000),
    hits_t'(23'h600000)
  };

  typedef struct packed {
    byte_t text;
    logic  has;
    logic  last;
  } prompt_word_t;

  // --------------------------------------------------------------------------
  // Scoreboard: keyword scan of accepted words and queue of expected replies
  // --------------------------------------------------------------------------
  class reply_scoreboard;
    string  keywords [KEYWORD_COUNT];
    byte_t  history [HISTORY_LEN];
    int     fill;
    hits_t  seen;
    reply_t expected_q [$];
    int     failures;

    function new();
      keywords = '{
        "gravity", "spanish", "translate", "summar", "reply", "helpfully",
        "intent", "classify", "json", "extract", "weather", "one sentence",
        "explain", "test failure", "fix this", "endpoint", "/health",
        "rename", "refactor", "unit test", "write a test", "debug", "error"
      };
      failures = 0;
      clear_prompt();
    endfunction

    function void clear_prompt();
      foreach (history[i]) history[i] = 8'h00;
      fill = 0;
      seen = '0;
    endfunction

    function byte_t lower_case(byte_t c);
      if (c >= 8'h41 && c <= 8'h5A) begin
        return c + 8'h20;
      end
      return c;
    endfunction

    // Newest byte plus history against every keyword, then shift
    function void scan_byte(byte_t c);
      byte_t window [WINDOW_LEN];
      int    len;
      bit    hit;
      window[0] = lower_case(c);
      for (int j = 1; j < WINDOW_LEN; j++) window[j] = history[j-1];
      for (int k = 0; k < KEYWORD_COUNT; k++) begin
        len = keywords[k].len();
        if (len <= fill + 1) begin
          hit = 1'b1;
          for (int j = 0; j < len; j++) begin
            if (byte_t'(keywords[k][len-1-j]) != window[j]) hit = 1'b0;
          end
          if (hit) seen[k] = 1'b1;
        end
      end
      for (int j = HISTORY_LEN - 1; j > 0; j--) history[j] = history[j-1];
      history[0] = window[0];
      if (fill < HISTORY_LEN) fill++;
    endfunction

    function reply_t first_rule_hit();
      hits_t got;
      for (int r = 0; r < RULE_COUNT; r++) begin
        got = seen & RULE_KEYS[r];
        if (r == BOTH_KEYS_RULE ? (got == RULE_KEYS[r]) : (got != '0)) begin
          return reply_t'(r);
        end
      end
      return DEFAULT_REPLY;
    endfunction

    function void flag(string msg);
      failures++;
      if (failures <= REPORT_LIMIT) $display("%s", msg);
    endfunction

    function void note_word(prompt_word_t w);
      if (w.has) scan_byte(w.text);
      if (w.last) begin
        expected_q.push_back(first_rule_hit());
        clear_prompt();
      end
    endfunction

    function void check_reply(reply_t got);
      reply_t want;
      if (expected_q.size() == 0) begin
        flag($sformatf("unexpected reply word: reply_index %0d", got));
        return;
      end
      want = expected_q.pop_front();
      if (got !== want) begin
        flag($sformatf("reply_index mismatch: expected %0d, got %0d", want, got));
      end
    endfunction

    function int waiting();
      return expected_q.size();
    endfunction

    function void close_run();
      if (expected_q.size() != 0) begin
        flag($sformatf("%0d reply words never arrived", expected_q.size()));
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset, channels and block
  // --------------------------------------------------------------------------
  logic clk;
  logic rst;

  pkrc_in_if  prompt_if ();
  pkrc_out_if reply_if ();

  prompt_keyword_rule_classifier i_dut (
    .clk       (clk),
    .rst       (rst),
    .prompt_in (prompt_if),
    .reply_out (reply_if)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  reply_scoreboard sb;
  prompt_word_t    prompt_words [$];
  int              send_idle_pct  = 20;
  int              recv_stall_pct = 73;
  int              words_sent     = 0;
  int              quiet_cycles   = 0;

  // Reply side: random stalls
  always @(posedge clk) begin
    reply_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Check each reply word as it is taken
  always @(posedge clk) begin
    if (!rst && reply_if.valid && reply_if.ready) begin
      sb.check_reply(reply_if.reply_index);
    end
  end

  // Watchdog on cycles with no word moving on either side
  always @(posedge clk) begin
    if (rst || (prompt_if.valid && prompt_if.ready) ||
        (reply_if.valid && reply_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Prompt building
  // --------------------------------------------------------------------------
  function void push_word(byte_t text, logic has, logic last);
    prompt_word_t w;
    w.text = text;
    w.has  = has;
    w.last = last;
    prompt_words.push_back(w);
  endfunction

  function void push_text(string s);
    for (int i = 0; i < s.len(); i++) push_word(byte_t'(s[i]), 1'b1, 1'b0);
  endfunction

  // A byte, sometimes behind an ignored word
  function void push_char(byte_t c);
    if ($urandom_range(0, 19) == 0) push_word(8'($urandom), 1'b0, 1'b0);
    push_word(c, 1'b1, 1'b0);
  endfunction

  // Keyword in mixed case, sometimes missing its final letter
  function void push_keyword(int k);
    string s;
    int    n;
    byte_t c;
    s = sb.keywords[k];
    n = s.len();
    if ($urandom_range(0, 99) < 15) n--;
    for (int i = 0; i < n; i++) begin
      c = byte_t'(s[i]);
      if (c >= 8'h61 && c <= 8'h7A && $urandom_range(0, 2) == 0) c = c - 8'h20;
      push_char(c);
    end
  endfunction

  function void push_filler();
    string pool;
    byte_t c;
    pool = "abcdefghijklmnopqrstuvwxyz ./ ";
    for (int i = $urandom_range(1, 6); i > 0; i--) begin
      c = byte_t'(pool[$urandom_range(0, pool.len() - 1)]);
      if (c >= 8'h61 && c <= 8'h7A && $urandom_range(0, 1) == 0) c = c - 8'h20;
      push_char(c);
    end
  endfunction

  // Last flag on the final byte, or on a separate empty word
  function void close_prompt(bit apart);
    if (apart || prompt_words.size() == 0 || !prompt_words[$].has) begin
      push_word(8'($urandom), 1'b0, 1'b1);
    end else begin
      prompt_words[$].last = 1'b1;
    end
  endfunction

  function void build_random_prompt();
    int kind;
    int chunks;
    prompt_words.delete();
    chunks = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 5);
    for (int c = 0; c < chunks; c++) begin
      kind = $urandom_range(0, 99);
      if (kind < 45) begin
        push_keyword($urandom_range(0, KEYWORD_COUNT - 1));
      end else if (kind < 55) begin
        push_keyword(21);
        if ($urandom_range(0, 1)) push_filler();
        push_keyword(22);
      end else if (kind < 80) begin
        push_filler();
      end else begin
        for (int i = $urandom_range(1, 4); i > 0; i--) push_char(8'($urandom));
      end
    end
    close_prompt($urandom_range(0, 3) == 0);
  endfunction

  // --------------------------------------------------------------------------
  // Driving
  // --------------------------------------------------------------------------
  task automatic send_word(prompt_word_t w);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      prompt_if.valid       <= 1'b0;
      prompt_if.prompt_byte <= 8'($urandom);
      @(posedge clk);
    end
    prompt_if.valid       <= 1'b1;
    prompt_if.prompt_byte <= w.text;
    prompt_if.has_byte    <= w.has;
    prompt_if.last_byte   <= w.last;
    @(posedge clk);
    while (!prompt_if.ready) @(posedge clk);
    sb.note_word(w);
  endtask

  task automatic send_prompt();
    foreach (prompt_words[i]) begin
      send_word(prompt_words[i]);
      words_sent++;
    end
    prompt_words.delete();
  endtask

  // Hold off until every reply is back
  task automatic drain();
    prompt_if.valid <= 1'b0;
    @(posedge clk);
    while (sb.waiting() != 0) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    int target;
    sb = new();
    rst                   <= 1'b1;
    prompt_if.valid       <= 1'b0;
    prompt_if.prompt_byte <= 8'h00;
    prompt_if.has_byte    <= 1'b0;
    prompt_if.last_byte   <= 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Empty prompt straight after reset
    push_word(8'hA5, 1'b0, 1'b1);
    // Upper case keyword with an ignored word inside it
    push_text("JS");
    push_word(8'hFF, 1'b0, 1'b0);
    push_text("ON");
    close_prompt(1'b0);
    // Zero byte breaks a match
    push_text("jso");
    push_word(8'h00, 1'b1, 1'b0);
    push_text("n");
    close_prompt(1'b0);
    // High byte alone
    push_word(8'hFF, 1'b1, 1'b1);
    // Keyword split across two prompts must not match
    push_text("grav");
    close_prompt(1'b0);
    push_text("ity");
    close_prompt(1'b0);
    // Mixed case keyword closed by a separate empty word
    push_text("Reply");
    close_prompt(1'b1);
    send_prompt();

    // Random prompts in three idling regimes
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct  = (phase == 0) ? 20 : (phase == 1) ? 73 : 0;
      recv_stall_pct = (phase == 0) ? 73 : (phase == 1) ? 20 : 0;
      target = words_sent + PHASE_WORDS;
      while (words_sent < target) begin
        build_random_prompt();
        send_prompt();
      end
      drain();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    sb.close_run();
    if (sb.failures == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

@@ sim.f @@
src/pkrc_pkg.sv
src/pkrc_if.sv
src/pkrc_match.sv
src/pkrc_select.sv
src/prompt_keyword_rule_classifier.sv
sim/prompt_keyword_rule_classifier_test.sv
